// ===== rtl/sfr_pkg.sv =====
// Shared constants, types and the CRC step function of the serial frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

	// Default frame length in bytes.
	localparam int FRAME_BYTES_DEF = 25;

	// Fixed field layout of a frame.
	localparam int HELD_BYTES     = 23;	// bytes 0..22 carry the latched fields
	localparam int TRIP_KEEP_FROM = 19;	// bytes from here on (cell current) survive a trip
	localparam int OUT_DATA_W     = 8 * HELD_BYTES;
	localparam int OUT_USER_W     = 3;

	// Link constants.
	localparam logic [7:0] END_MARK   = 8'h17;
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] CRC_INIT   = 8'hFF;
	localparam logic [5:0] IDLE_MAX   = 6'd63;
	localparam logic [7:0] REJECT_MAX = 8'd255;

	// Eight shift steps per cycle and four CRC phases per byte (32 steps).
	localparam int CRC_PHASES = 4;

	// Configuration registers.
	localparam int          CFG_INDEX_W = 8;
	localparam int          CFG_DATA_W  = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_GAP_TICKS    = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_REJECT_LIMIT = 8'd1;
	localparam logic [5:0] GAP_TICKS_RST    = 6'd25;
	localparam logic [7:0] REJECT_LIMIT_RST = 8'd100;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK_RD,
		ST_CHK_CALC,
		ST_LAT_RD,
		ST_LAT_WR,
		ST_FIN
	} state_t;

	// Eight consecutive shift steps of the CRC register. When use_d is set the
	// data bits are applied MSB first, one per step.
	function automatic logic [7:0] crc8_steps(input logic [7:0] c_in, input logic [7:0] d,
		input logic use_d);
		logic [7:0] c;
		logic       top;
		c = c_in;
		for (int s = 0; s < 8; s++) begin
			top = c[7];
			c = {c[6:0], 1'b0};
			if (top) begin
				c = c ^ CRC_POLY;
			end
			if (use_d && d[7-s]) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/sfr_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module sfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/serial_frame_receiver_crc8.sv =====
// Top level of the serial frame receiver with CRC-8 frame check.
`timescale 1ns / 1ps

// Usage
// The slave channel (s_tvalid, s_tready, s_tdata, s_tuser) carries one line event per
// transaction: s_tuser 0 delivers the received byte in s_tdata, s_tuser 1 is one time tick.
// The master channel returns exactly one result transaction for every input transaction:
// m_tlast marks the transaction that closed a frame, m_tuser holds the ok, fault and trip
// flags, and m_tdata holds the latched frame fields.
// The cfg channel writes gap_ticks (index 0) and reject_limit (index 1); it is always
// ready and other indexes are ignored. Write it only while the block is idle.
// A byte or a tick that does not close a frame gives its result in the cycle after
// acceptance. A closing tick walks the frame store held in a RAM with registered read:
// for bytes 0..FRAME_BYTES-2 one read and four CRC phases of eight shift steps each,
// then a read and a compare for the check byte, then, for a good frame, a read and a
// write per latched byte for the 23 field bytes, and one closing state. One item is
// in work at a time.
// A new item is accepted only when the previous result has been taken or is taken in the
// same cycle; a stalled master therefore holds off the slave side.
// Reset clears the frame store (through per-entry valid bits), counters and fields, sets
// the fault flag, and loads gap_ticks 25 and reject_limit 100. No clearing pass is needed.

module serial_frame_receiver_crc8 #(
	parameter int FRAME_BYTES = sfr_pkg::FRAME_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,	// [7:0] rx_byte
	input  logic                             s_tuser,	// [0] opcode
	// Result stream.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] emergency_flag, [39:8] cell_voltage, [71:40] cell_temperature,
	// [103:72] transfer_current, [135:104] capacitor_voltage, [151:136] fan_speed,
	// [183:152] cell_current
	output logic [sfr_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic [sfr_pkg::OUT_USER_W-1:0]   m_tuser,	// [0] frame_ok, [1] fault, [2] link_trip
	output logic                             m_tlast,	// frame_end
	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int IW = $clog2(FRAME_BYTES);
	localparam int PW = $clog2(FRAME_BYTES + 1);
	localparam logic [IW-1:0] LAST_IDX  = IW'(FRAME_BYTES - 1);
	localparam logic [IW-1:0] MARK_IDX  = IW'(FRAME_BYTES - 2);
	localparam logic [IW-1:0] HELD_LAST = IW'(sfr_pkg::HELD_BYTES - 1);
	localparam logic [PW-1:0] POS_FULL  = PW'(FRAME_BYTES);
	localparam logic [1:0]    PH_LAST   = 2'(sfr_pkg::CRC_PHASES - 1);

	sfr_pkg::state_t st_q, st_nx;

	// Configuration.
	logic [5:0] gap_q;
	logic [7:0] limit_q;

	// Receive state.
	logic [PW-1:0]          pos_q;
	logic [5:0]             idle_q;
	logic                   seen_q;
	logic [FRAME_BYTES-1:0] vld_q;
	logic [7:0]             rej_q;
	logic                   fault_q;
	logic [7:0]             held_q [sfr_pkg::HELD_BYTES];

	// Close sequence.
	logic [IW-1:0] idx_q;
	logic [1:0]    ph_q;
	logic [7:0]    crc_q;
	logic          mark_q;
	logic          ok_q;
	logic          vld_s1;

	// Output register.
	logic out_vld_q, out_end_q, out_ok_q, out_trip_q;

	// Combinational helpers.
	logic       in_acc, is_tick, is_byte, do_close, chk_ok, out_free;
	logic [5:0] idle_nx;
	logic [7:0] bval, rej_nx;
	logic       trip_w;

	logic          ram_we, ram_re;
	logic [7:0]    ram_rdata;

	assign cfg_ready = 1'b1;

	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (st_q == sfr_pkg::ST_IDLE) && out_free;
	assign in_acc   = s_tvalid && s_tready;
	assign is_tick  = in_acc && s_tuser;
	assign is_byte  = in_acc && !s_tuser;

	// Idle counting: a tick right after bytes only consumes the byte flag.
	always_comb begin
		idle_nx = idle_q;
		if (!seen_q && idle_q < sfr_pkg::IDLE_MAX) begin
			idle_nx = idle_q + 6'd1;
		end
	end
	assign do_close = is_tick && (idle_nx > gap_q);

	// Entries never written since the last close read as zero.
	assign bval   = vld_s1 ? ram_rdata : 8'd0;
	assign chk_ok = mark_q && (crc_q == bval);

	assign rej_nx = (rej_q < sfr_pkg::REJECT_MAX) ? rej_q + 8'd1 : rej_q;
	assign trip_w = !ok_q && (rej_nx > limit_q);

	// Writes happen only on byte items in the idle state and reads only during a close,
	// so the two ports never touch the RAM in the same cycle.
	assign ram_we = is_byte && (pos_q < POS_FULL);
	assign ram_re = (st_q == sfr_pkg::ST_CHK_RD) || (st_q == sfr_pkg::ST_LAT_RD);

	sfr_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_q[IW-1:0]),
		.wdata(s_tdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sfr_pkg::ST_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end

	always_comb begin
		st_nx = st_q;
		case (st_q)
			sfr_pkg::ST_IDLE: begin
				if (do_close) begin
					st_nx = sfr_pkg::ST_CHK_RD;
				end
			end
			sfr_pkg::ST_CHK_RD: begin
				st_nx = sfr_pkg::ST_CHK_CALC;
			end
			sfr_pkg::ST_CHK_CALC: begin
				if (idx_q == LAST_IDX) begin
					st_nx = chk_ok ? sfr_pkg::ST_LAT_RD : sfr_pkg::ST_FIN;
				end else if (ph_q == PH_LAST) begin
					st_nx = sfr_pkg::ST_CHK_RD;
				end
			end
			sfr_pkg::ST_LAT_RD: begin
				st_nx = sfr_pkg::ST_LAT_WR;
			end
			sfr_pkg::ST_LAT_WR: begin
				st_nx = (idx_q == HELD_LAST) ? sfr_pkg::ST_FIN : sfr_pkg::ST_LAT_RD;
			end
			sfr_pkg::ST_FIN: begin
				st_nx = sfr_pkg::ST_IDLE;
			end
			default: begin
				st_nx = sfr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q      <= sfr_pkg::GAP_TICKS_RST;
			limit_q    <= sfr_pkg::REJECT_LIMIT_RST;
			pos_q      <= '0;
			idle_q     <= '0;
			seen_q     <= 1'b0;
			vld_q      <= '0;
			rej_q      <= '0;
			fault_q    <= 1'b1;
			for (int i = 0; i < sfr_pkg::HELD_BYTES; i++) begin
				held_q[i] <= '0;
			end
			idx_q      <= '0;
			ph_q       <= '0;
			crc_q      <= sfr_pkg::CRC_INIT;
			mark_q     <= 1'b0;
			ok_q       <= 1'b0;
			vld_s1     <= 1'b0;
			out_vld_q  <= 1'b0;
			out_end_q  <= 1'b0;
			out_ok_q   <= 1'b0;
			out_trip_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == sfr_pkg::CFG_GAP_TICKS) begin
					gap_q <= cfg_data[5:0];
				end else if (cfg_index == sfr_pkg::CFG_REJECT_LIMIT) begin
					limit_q <= cfg_data;
				end
			end

			// A new result enters the output register when an item ends; otherwise a
			// taken result leaves it.
			if (is_byte || (is_tick && !do_close) || st_q == sfr_pkg::ST_FIN) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end

			if (ram_re) begin
				vld_s1 <= vld_q[idx_q];
			end

			// Items that do not close a frame load the output register at once.
			if (is_byte) begin
				if (pos_q < POS_FULL) begin
					vld_q[pos_q[IW-1:0]] <= 1'b1;
					pos_q <= pos_q + PW'(1);
				end
				seen_q     <= 1'b1;
				out_end_q  <= 1'b0;
				out_ok_q   <= 1'b0;
				out_trip_q <= 1'b0;
			end

			if (is_tick) begin
				seen_q <= 1'b0;
				if (do_close) begin
					idle_q <= '0;
					pos_q  <= '0;
					idx_q  <= '0;
					ph_q   <= '0;
					crc_q  <= sfr_pkg::CRC_INIT;
					mark_q <= 1'b0;
				end else begin
					idle_q     <= idle_nx;
					out_end_q  <= 1'b0;
					out_ok_q   <= 1'b0;
					out_trip_q <= 1'b0;
				end
			end

			case (st_q)
				sfr_pkg::ST_CHK_CALC: begin
					if (idx_q == LAST_IDX) begin
						ok_q  <= chk_ok;
						idx_q <= '0;
					end else begin
						crc_q <= sfr_pkg::crc8_steps(crc_q, bval, ph_q == 2'd0);
						if (idx_q == MARK_IDX && ph_q == 2'd0) begin
							mark_q <= (bval == sfr_pkg::END_MARK);
						end
						ph_q <= ph_q + 2'd1;
						if (ph_q == PH_LAST) begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				sfr_pkg::ST_LAT_WR: begin
					held_q[idx_q[$clog2(sfr_pkg::HELD_BYTES)-1:0]] <= bval;
					idx_q <= idx_q + IW'(1);
				end
				sfr_pkg::ST_FIN: begin
					// Every close empties the store.
					vld_q <= '0;
					if (ok_q) begin
						fault_q <= 1'b0;
						rej_q   <= '0;
					end else begin
						rej_q <= rej_nx;
						if (trip_w) begin
							fault_q <= 1'b1;
							for (int i = 0; i < sfr_pkg::TRIP_KEEP_FROM; i++) begin
								held_q[i] <= '0;
							end
						end
					end
					out_end_q  <= 1'b1;
					out_ok_q   <= ok_q;
					out_trip_q <= trip_w;
				end
				default: begin
				end
			endcase
		end
	end

	// The held fields and the fault flag change only while no result is pending, so they
	// drive the result payload straight from their registers.
	assign m_tvalid = out_vld_q;
	assign m_tlast  = out_end_q;
	assign m_tuser  = {out_trip_q, fault_q, out_ok_q};

	for (genvar g = 0; g < sfr_pkg::HELD_BYTES; g++) begin : g_out
		assign m_tdata[8*g +: 8] = held_q[g];
	end

endmodule
